[sv/cle_pkg.sv]
// Package with the request codes, status codes and default sizes of the circular list engine.
package cle_pkg;

    // Default sizes.
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Request codes.
    localparam logic [2:0] REQ_READ       = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD   = 3'd1;
    localparam logic [2:0] REQ_INS_TAIL   = 3'd2;
    localparam logic [2:0] REQ_INS_AFTER  = 3'd3;
    localparam logic [2:0] REQ_DEL_HEAD   = 3'd4;
    localparam logic [2:0] REQ_DEL_TAIL   = 3'd5;
    localparam logic [2:0] REQ_DEL_KEY    = 3'd6;
    localparam logic [2:0] REQ_UNUSED     = 3'd7;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

[sv/circular_list_engine_core.sv]
// Circular singly linked list engine kept in a slot store, walked one node per cycle.
// Inserts at head or tail finish in S_IDLE or pass through S_LINK; deletes, key search and read-out
// walk the list in S_WALK, and insert-after then passes through S_LINK.
// One request at a time; busy stays high until the last result is shown.
// The walk is set by the registered read port of the node store feeding the next address.
// Reset (rst_n low, asynchronous) empties the list; results cannot be stalled by the receiver.
module circular_list_engine_core #(
    parameter int CAPACITY   = cle_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = cle_pkg::DEF_DATA_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    input  logic signed [31:0] key,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] data_out,
    output logic               last
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // Node store.
    data_t node_value [CAPACITY];
    idx_t  node_link  [CAPACITY];

    logic [1:0]     state_reg, state_next;
    logic [CAPACITY-1:0] used_reg, used_next;
    idx_t           head_reg, head_next;
    idx_t           tail_reg, tail_next;
    cnt_t           count_reg, count_next;
    logic [2:0]     op_reg, op_next;
    data_t          val_reg, val_next;
    data_t          key_reg, key_next;
    idx_t           free_reg, free_next;
    idx_t           cur_reg, cur_next;
    idx_t           prev_reg, prev_next;
    cnt_t           n_reg, n_next;

    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    logic signed [31:0] data_out_reg, data_out_next;
    logic           last_reg, last_next;

    // Store ports.
    logic  val_we, link_we;
    idx_t  val_waddr, link_waddr, raddr;
    data_t val_wdata, val_q;
    idx_t  link_wdata, link_q;

    idx_t  free_slot;
    logic  is_last, match;
    idx_t  rm_slot, rm_prev, rm_next;

    // Lowest unused slot.
    always_comb
    begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    // Store write and registered read.
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            node_value[val_waddr] <= val_wdata;
        end
        if (link_we)
        begin
            node_link[link_waddr] <= link_wdata;
        end
        val_q  <= node_value[raddr];
        link_q <= node_link[raddr];
    end

    // Walk conditions.
    always_comb
    begin
        is_last = (n_reg + cnt_t'(1)) == count_reg;
        unique case (op_reg)
            cle_pkg::REQ_DEL_HEAD: match = 1'b1;
            cle_pkg::REQ_DEL_TAIL: match = (link_q == tail_reg);
            default:               match = (val_q == key_reg);
        endcase
        if (op_reg == cle_pkg::REQ_DEL_TAIL)
        begin
            rm_slot = tail_reg;
            rm_prev = cur_reg;
            rm_next = head_reg;
        end
        else
        begin
            rm_slot = cur_reg;
            rm_prev = prev_reg;
            rm_next = link_q;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        key_next      = key_reg;
        free_next     = free_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        n_next        = n_reg;
        done_next     = 1'b0;
        status_next   = cle_pkg::ST_OK;
        data_out_next = '0;
        last_next     = 1'b0;
        val_we        = 1'b0;
        link_we       = 1'b0;
        val_waddr     = free_reg;
        link_waddr    = free_reg;
        val_wdata     = val_reg;
        link_wdata    = head_reg;
        raddr         = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = head_reg;
                if (start)
                begin
                    op_next   = req_type;
                    val_next  = DATA_WIDTH'(value);
                    key_next  = DATA_WIDTH'(key);
                    free_next = free_slot;
                    cur_next  = head_reg;
                    prev_next = tail_reg;
                    n_next    = '0;
                    unique case (req_type)
                        cle_pkg::REQ_READ,
                        cle_pkg::REQ_DEL_HEAD,
                        cle_pkg::REQ_DEL_TAIL,
                        cle_pkg::REQ_DEL_KEY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = cle_pkg::ST_EMPTY;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        cle_pkg::REQ_INS_HEAD,
                        cle_pkg::REQ_INS_TAIL,
                        cle_pkg::REQ_INS_AFTER:
                        begin
                            if (count_reg == cnt_t'(CAPACITY))
                            begin
                                done_next   = 1'b1;
                                status_next = cle_pkg::ST_FULL;
                                last_next   = 1'b1;
                            end
                            else if (req_type == cle_pkg::REQ_INS_AFTER)
                            begin
                                if (count_reg == '0)
                                begin
                                    done_next   = 1'b1;
                                    status_next = cle_pkg::ST_NOTFOUND;
                                    last_next   = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_WALK;
                                end
                            end
                            else
                            begin
                                // Write the new node and link it to the old head, or to itself when the list is empty.
                                val_we     = 1'b1;
                                val_waddr  = free_slot;
                                val_wdata  = DATA_WIDTH'(value);
                                link_we    = 1'b1;
                                link_waddr = free_slot;
                                if (count_reg == '0)
                                begin
                                    link_wdata = free_slot;
                                    head_next  = free_slot;
                                    tail_next  = free_slot;
                                    used_next[free_slot] = 1'b1;
                                    count_next = count_reg + cnt_t'(1);
                                    done_next  = 1'b1;
                                    last_next  = 1'b1;
                                end
                                else
                                begin
                                    link_wdata = head_reg;
                                    state_next = S_LINK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                raddr = link_q;
                if (op_reg == cle_pkg::REQ_READ)
                begin
                    done_next     = 1'b1;
                    data_out_next = 32'(val_q);
                    last_next     = is_last;
                    cur_next      = link_q;
                    n_next        = n_reg + cnt_t'(1);
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (match)
                begin
                    if (op_reg == cle_pkg::REQ_INS_AFTER)
                    begin
                        // New node takes over the successor of the found node.
                        val_we     = 1'b1;
                        val_waddr  = free_reg;
                        val_wdata  = val_reg;
                        link_we    = 1'b1;
                        link_waddr = free_reg;
                        link_wdata = link_q;
                        state_next = S_LINK;
                    end
                    else
                    begin
                        // Unlink the node.
                        used_next[rm_slot] = 1'b0;
                        count_next = count_reg - cnt_t'(1);
                        if (count_reg == cnt_t'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = rm_prev;
                            link_wdata = rm_next;
                            if (rm_slot == head_reg)
                            begin
                                head_next = rm_next;
                            end
                            if (rm_slot == tail_reg)
                            begin
                                tail_next = rm_prev;
                            end
                        end
                        done_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (is_last && op_reg != cle_pkg::REQ_DEL_TAIL)
                begin
                    done_next   = 1'b1;
                    status_next = cle_pkg::ST_NOTFOUND;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_q;
                    n_next    = n_reg + cnt_t'(1);
                end
            end

            S_LINK:
            begin
                // Point the predecessor at the new node.
                link_we    = 1'b1;
                link_wdata = free_reg;
                if (op_reg == cle_pkg::REQ_INS_AFTER)
                begin
                    link_waddr = cur_reg;
                    if (cur_reg == tail_reg)
                    begin
                        tail_next = free_reg;
                    end
                end
                else
                begin
                    link_waddr = tail_reg;
                    if (op_reg == cle_pkg::REQ_INS_HEAD)
                    begin
                        head_next = free_reg;
                    end
                    else
                    begin
                        tail_next = free_reg;
                    end
                end
                used_next[free_reg] = 1'b1;
                count_next = count_reg + cnt_t'(1);
                done_next  = 1'b1;
                last_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        free_reg     <= free_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        n_reg        <= n_next;
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign data_out = data_out_reg;
    assign last     = last_reg;

endmodule
